// ----- src/olr_pkg.sv -----
// Shared types, codes and defaults for the ordered list store.
`timescale 1ns / 1ps
`default_nettype none

package olr_pkg;

   // Default number of entries the list can hold.
   localparam int CAPACITY_DEF = 32;

   localparam int VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   // Operation codes carried on req_func.
   localparam logic [1:0] FUNC_PUSH_FRONT = 2'd0;
   localparam logic [1:0] FUNC_PUSH_BACK  = 2'd1;
   localparam logic [1:0] FUNC_REMOVE     = 2'd2;
   localparam logic [1:0] FUNC_READOUT    = 2'd3;

   // Status codes carried on rsp_out_status.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Per-cycle commands broadcast to every cell of the chain.
   localparam logic [1:0] CELL_HOLD       = 2'd0;
   localparam logic [1:0] CELL_PUSH_FRONT = 2'd1;
   localparam logic [1:0] CELL_APPEND     = 2'd2;
   localparam logic [1:0] CELL_ROTATE     = 2'd3;

   typedef struct packed {
      logic [1:0] op;    // one of the CELL_* commands
      logic       keep;  // on rotate: re-append the head entry at the tail
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- src/ordered_list_remove_by_key.sv -----
// Top level of the ordered list store: cell chain, sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps up to CAPACITY signed 32-bit values in order, front to back,
// in a chain of cells; cell 0 always holds the front entry and the occupied
// cells form one unbroken run from it. Insert at front shifts the whole chain
// one place back, and insert at back fills the first free cell; an insert
// item gives one status item (full when the last cell is already occupied).
// Remove and readout walk the list by rotating the chain toward the front once
// per stored entry: the head entry drops off and is appended again at the
// tail, unless it is being removed. After as many rotations as there were
// entries the list is back in its original order, less the removed ones. A
// remove item therefore holds the block until its rotations are done (none on
// an empty list) and gives one status item; a readout item likewise holds it,
// giving one item per entry with the final one marked last, and stretches
// whenever the consumer stalls. An empty readout gives a single item with
// status empty. The rotation length, up to CAPACITY entries, sets how long an
// item holds the block.
// A new item is taken only when the sequencer is idle and the result register
// is free or being emptied in the same cycle.

module ordered_list_remove_by_key
   import olr_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Operation items.
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire value_type   req_item_value,
   // Result items.
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output value_type        rsp_out_value,
   output logic [1:0]       rsp_out_status,
   output logic             rsp_out_last
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Sequencer states.
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_REMOVE = 2'd1;
   localparam logic [1:0] S_READ   = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;   // entries stored
   logic [CNT_W-1:0] steps_ff, steps_in;   // rotations still to do
   value_type        key_ff, key_in;

   logic             rsp_valid_ff, rsp_valid_in;
   value_type        rsp_value_ff, rsp_value_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             cell_valid [CAPACITY];
   value_type        cell_value [CAPACITY];
   cell_ctrl_type    ctrl;

   logic             out_free;
   logic             accept;
   logic             full;
   logic             empty;
   logic             final_step;
   logic             step;
   logic             rsp_load;
   value_type        head_value;

   // ---------------------------------------------------------------------------
   // Cell chain. Each cell sees its two neighbors; the front cell sees the new value, the back cell an empty edge.
   // ---------------------------------------------------------------------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      left_valid;
      value_type left_value;
      logic      right_valid;
      value_type right_value;

      if (i == 0) begin : g_front
         assign left_valid = 1'b1;
         assign left_value = req_item_value;
      end else begin : g_inner_left
         assign left_valid = cell_valid[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_back
         assign right_valid = 1'b0;
         assign right_value = '0;
      end else begin : g_inner_right
         assign right_valid = cell_valid[i+1];
         assign right_value = cell_value[i+1];
      end

      olr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_value   (req_item_value),
         .head_value  (head_value),
         .left_valid  (left_valid),
         .left_value  (left_value),
         .right_valid (right_valid),
         .right_value (right_value),
         .valid       (cell_valid[i]),
         .value       (cell_value[i])
      );
   end

   assign head_value = cell_value[0];
   assign full       = cell_valid[CAPACITY-1];
   assign empty      = !cell_valid[0];

   // ---------------------------------------------------------------------------
   // Handshake and sequencing.
   // ---------------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == S_IDLE) && out_free);
   assign accept     = req_valid && !req_stall;
   assign final_step = (steps_ff == CNT_W'(1));

   // A remove rotation only needs the result register on its final step; a
   // readout rotation emits an item on every step.
   assign step = ((state_ff == S_REMOVE) && (!final_step || out_free)) ||
                 ((state_ff == S_READ) && out_free);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      steps_in      = steps_ff;
      key_in        = key_ff;
      ctrl.op       = CELL_HOLD;
      ctrl.keep     = 1'b1;
      rsp_load      = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = STATUS_OK;
      rsp_last_in   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                     rsp_load = 1'b1;
                     if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ctrl.op  = (req_func == FUNC_PUSH_FRONT) ? CELL_PUSH_FRONT
                                                                 : CELL_APPEND;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_REMOVE: begin
                     if (empty) begin
                        rsp_load = 1'b1;
                     end else begin
                        key_in   = req_item_value;
                        steps_in = count_ff;
                        state_in = S_REMOVE;
                     end
                  end
                  FUNC_READOUT: begin
                     if (empty) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        steps_in = count_ff;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_REMOVE: begin
            if (step) begin
               ctrl.op   = CELL_ROTATE;
               ctrl.keep = (head_value != key_ff);
               if (head_value == key_ff) begin
                  count_in = count_ff - CNT_W'(1);
               end
               steps_in = steps_ff - CNT_W'(1);
               if (final_step) begin
                  rsp_load = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_READ: begin
            if (step) begin
               ctrl.op      = CELL_ROTATE;
               ctrl.keep    = 1'b1;
               rsp_load     = 1'b1;
               rsp_value_in = head_value;
               rsp_last_in  = final_step;
               steps_in     = steps_ff - CNT_W'(1);
               if (final_step) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff <= key_in;
      if (rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_value  = rsp_value_ff;
   assign rsp_out_status = rsp_status_ff;
   assign rsp_out_last   = rsp_last_ff;

endmodule

`default_nettype wire

// ----- src/olr_cell.sv -----
// One storage cell of the list chain: a value and its occupied flag.
`timescale 1ns / 1ps
`default_nettype none

module olr_cell
   import olr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire value_type     new_value,
   input  wire value_type     head_value,
   input  wire logic          left_valid,
   input  wire value_type     left_value,
   input  wire logic          right_valid,
   input  wire value_type     right_value,
   output logic               valid,
   output value_type          value
);

   logic      valid_ff;
   logic      valid_in;
   value_type value_ff;
   value_type value_in;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      case (ctrl.op)
         CELL_PUSH_FRONT: begin
            // Everything moves one place toward the back.
            valid_in = left_valid;
            value_in = left_value;
         end
         CELL_APPEND: begin
            // Only the first free cell takes the new entry.
            if (!valid_ff && left_valid) begin
               valid_in = 1'b1;
               value_in = new_value;
            end
         end
         CELL_ROTATE: begin
            // Everything moves one place toward the front; the old tail cell
            // takes the head entry when it is kept.
            valid_in = right_valid | (valid_ff & ctrl.keep);
            value_in = right_valid ? right_value : head_value;
         end
         default: begin
            valid_in = valid_ff;
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule

`default_nettype wire

// ----- src/olr_checker.sv -----
// Port-level checks for the ordered list store, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module olr_checker
   import olr_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire value_type  rsp_out_value,
   input wire logic [1:0] rsp_out_status,
   input wire logic       rsp_out_last
);

   // Reset leaves no result item pending.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item pending after reset");

   // A stalled result item keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && rsp_stall) |-> rsp_valid && $stable(rsp_out_value) &&
      $stable(rsp_out_status) && $stable(rsp_out_last))
      else $error("stalled result item changed");

   // Full and empty reports are single items carrying a zero value.
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_status != STATUS_OK) |->
      rsp_out_last && (rsp_out_value == '0))
      else $error("error status on a non-final or nonzero item");

   // Only readout produces more than one item, and those are all ok.
   a_multi_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_last |-> rsp_out_status == STATUS_OK)
      else $error("non-final item with error status");

   // A new operation is taken only when the result register can accept.
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !rsp_valid || !rsp_stall)
      else $error("operation accepted while a result item is stalled");

endmodule

bind ordered_list_remove_by_key olr_checker u_olr_checker (.*);

`default_nettype wire
